// File: rtl/trie_keyword_stream_matcher_assert.svh
// Assertion macros used by the matcher RTL.
`ifndef TRIE_KEYWORD_STREAM_MATCHER_ASSERT_SVH
`define TRIE_KEYWORD_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TKM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tkm_pkg.sv
package tkm_pkg;

  localparam int MAX_NODES = 64;
  localparam int ARG_BITS  = 16;
  localparam int CH_BITS   = 8;
  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = $clog2(MAX_NODES + 1);

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_MATCH   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [NODE_BITS-1:0] parent;
    logic [CH_BITS-1:0]   chr;
    logic [ARG_BITS-1:0]  value;
  } node_entry_t;

  typedef struct packed {
    logic                 en;
    logic [NODE_BITS-1:0] addr;
    node_entry_t          entry;
    logic                 is_end;
  } node_wr_t;

  typedef struct packed {
    node_entry_t entry;
    logic        is_end;
  } node_rd_t;

endpackage

// File: rtl/tkm_node_table.sv
// Node table: one write port and one registered read port. The end marks
// live in flip-flops so that reset clears them; the rest is plain memory.
module tkm_node_table
  import tkm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NODE_BITS-1:0] rd_addr,
  output node_rd_t             rd_data,
  input  node_wr_t             wr
);

  node_entry_t          mem [MAX_NODES];
  logic [MAX_NODES-1:0] is_end;
  node_entry_t          rd_entry;
  logic                 rd_end;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_end <= '0;
    end else if (wr.en) begin
      is_end[wr.addr] <= wr.is_end;
    end
    rd_end <= is_end[rd_addr];
  end

  assign rd_data.entry  = rd_entry;
  assign rd_data.is_end = rd_end;

endmodule

// File: rtl/trie_keyword_stream_matcher.sv
// Trie keyword stream matcher.
// The input channel (in_valid/in_ready) carries one item per transfer:
// req_type 0 adds one keyword character (ch, word_end, end_arg) to the
// trie, req_type 1 matches one stream character. The output channel
// (out_valid/out_ready) returns exactly one result per item: hit, hit_arg
// and status (1 when the node table was full and a load was dropped).
// Each item is resolved by scanning the node table through its single
// registered read port, one node per cycle. A match that misses away
// from the root scans a second time from the root.
// The block takes one item at a time: in_ready is high only while idle.
// A finished result sits in the output register; the next item can be
// accepted while it waits, and a new result is held back until the
// receiver has taken the previous one, so a stalled receiver stalls the
// block without losing anything.
// Synchronous reset empties the trie (root only), returns both cursors to
// the root and drops any pending result. No memory clearing pass is needed.
module trie_keyword_stream_matcher
  import tkm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  ch,
  input  logic        word_end,
  input  logic [15:0] end_arg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [15:0] hit_arg,
  output logic        status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t               state;
  logic                 req_q;
  logic [CH_BITS-1:0]   ch_q;
  logic                 last_q;
  logic [ARG_BITS-1:0]  arg_q;
  logic [NODE_BITS-1:0] from;
  logic [CNT_BITS-1:0]  scan_idx;
  logic                 chk_valid;
  logic [NODE_BITS-1:0] chk_idx;
  logic [CNT_BITS-1:0]  nodes_used;
  logic [NODE_BITS-1:0] match_cursor;
  logic [NODE_BITS-1:0] load_cursor;
  logic                 res_hit;
  logic [ARG_BITS-1:0]  res_arg;
  logic                 res_status;

  node_rd_t rd;
  node_wr_t wr;
  logic     issue;
  logic     found;
  logic     scan_end;
  logic     table_full;

  tkm_node_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (scan_idx[NODE_BITS-1:0]),
    .rd_data (rd),
    .wr      (wr)
  );

  assign in_ready   = (state == ST_IDLE);
  assign table_full = (nodes_used >= CNT_BITS'(MAX_NODES));

  // A read is issued for every allocated node past the root. The compare
  // stage sees the registered data in the following cycle.
  assign issue    = (state == ST_SCAN) && (scan_idx < nodes_used);
  assign found    = chk_valid && (rd.entry.parent == from) && (rd.entry.chr == ch_q);
  assign scan_end = found || (!chk_valid && !issue);

  // Table writes happen only in the cycle in which a load is resolved.
  always_comb begin
    wr              = '0;
    wr.addr         = chk_idx;
    wr.entry.parent = from;
    wr.entry.chr    = ch_q;
    wr.entry.value  = arg_q;
    wr.is_end       = 1'b1;
    if ((state == ST_SCAN) && scan_end && (req_q == REQ_LOAD)) begin
      if (found) begin
        // On a word end, an existing node becomes (or stays) an end node.
        wr.en = last_q;
      end else if (!table_full) begin
        wr.en          = 1'b1;
        wr.addr        = nodes_used[NODE_BITS-1:0];
        wr.is_end      = last_q;
        wr.entry.value = last_q ? arg_q : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chk_valid    <= 1'b0;
      nodes_used   <= CNT_BITS'(1);
      match_cursor <= '0;
      load_cursor  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The output register loads a new result once the old one is gone.
      if ((state == ST_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_q     <= req_type;
            ch_q      <= ch;
            last_q    <= word_end;
            arg_q     <= end_arg[ARG_BITS-1:0];
            from      <= (req_type == REQ_LOAD) ? load_cursor : match_cursor;
            scan_idx  <= CNT_BITS'(1);
            chk_valid <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_valid <= issue;
          chk_idx   <= scan_idx[NODE_BITS-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CNT_BITS'(1);
          end
          if (scan_end) begin
            if (req_q == REQ_LOAD) begin
              res_hit <= 1'b0;
              res_arg <= '0;
              state   <= ST_FIN;
              if (found) begin
                res_status  <= STATUS_OK;
                load_cursor <= last_q ? '0 : chk_idx;
              end else if (!table_full) begin
                res_status  <= STATUS_OK;
                nodes_used  <= nodes_used + CNT_BITS'(1);
                load_cursor <= last_q ? '0 : nodes_used[NODE_BITS-1:0];
              end else begin
                res_status <= STATUS_FULL;
                if (last_q) begin
                  load_cursor <= '0;
                end
              end
            end else begin
              res_status <= STATUS_OK;
              if (found) begin
                match_cursor <= chk_idx;
                res_hit      <= rd.is_end;
                res_arg      <= rd.is_end ? rd.entry.value : '0;
                state        <= ST_FIN;
              end else if (from != '0) begin
                // Miss below the root: retry the same character at the root.
                // No read is in flight here, so the compare stage is already
                // empty for the new scan.
                match_cursor <= '0;
                from         <= '0;
                scan_idx     <= CNT_BITS'(1);
              end else begin
                match_cursor <= '0;
                res_hit      <= 1'b0;
                res_arg      <= '0;
                state        <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            hit     <= res_hit;
            hit_arg <= 16'(res_arg);
            status  <= res_status;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "trie_keyword_stream_matcher_assert.svh"

  // The node count only grows and never passes the table size.
  `TKM_ASSERT_NOW(a_used_range, 1'b1, (nodes_used >= CNT_BITS'(1)) && (nodes_used <= CNT_BITS'(MAX_NODES)), "node count out of range")
  `TKM_ASSERT_NEXT(a_used_grows, 1'b1, nodes_used >= $past(nodes_used), "node count decreased")
  // After a transfer in, the block is busy until the item is resolved.
  `TKM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  // A full-table status only comes from a load, which never hits.
  `TKM_ASSERT_NOW(a_status_no_hit, out_valid && (status == STATUS_FULL), !hit && (hit_arg == 16'd0), "hit reported with full status")

endmodule
